// ===== src/tfd_pkg.sv =====
// Shared constants, codes and helpers for the typed frame deframer.
`default_nettype none

package tfd_pkg;

  localparam int ByteW   = 8;
  localparam int PosW    = 7;
  localparam int StatusW = 3;
  localparam int PhaseW  = 2;
  localparam int NumLen  = 6;
  localparam int SlotW   = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 8;
  localparam int LenExtW = 9;

  localparam int MaxFrame = 128;
  localparam int MinFrame = 4;

  localparam logic [PhaseW-1:0] PH_HUNT = 2'd0;
  localparam logic [PhaseW-1:0] PH_KIND = 2'd1;
  localparam logic [PhaseW-1:0] PH_BODY = 2'd2;

  localparam logic [StatusW-1:0] ST_DROP = 3'd0;
  localparam logic [StatusW-1:0] ST_IN   = 3'd1;
  localparam logic [StatusW-1:0] ST_GOOD = 3'd2;
  localparam logic [StatusW-1:0] ST_KIND = 3'd3;
  localparam logic [StatusW-1:0] ST_STOP = 3'd4;
  localparam logic [StatusW-1:0] ST_SUM  = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_START    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STOP     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FAULT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ODOMETRY = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RANGE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VOLUME   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TRACE    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SETTING  = 3'd7;

  localparam logic [ByteW-1:0] KIND_FAULT    = 8'h02;
  localparam logic [ByteW-1:0] KIND_ODOMETRY = 8'h03;
  localparam logic [ByteW-1:0] KIND_RANGE    = 8'h04;
  localparam logic [ByteW-1:0] KIND_VOLUME   = 8'h05;
  localparam logic [ByteW-1:0] KIND_TRACE    = 8'h07;
  localparam logic [ByteW-1:0] KIND_SETTING  = 8'h08;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
  } kind_slot_t;

  // Map a kind byte to its length register slot.
  function automatic kind_slot_t kind_slot(input logic [ByteW-1:0] kind);
    kind_slot_t r;
    r.valid = 1'b1;
    case (kind)
      KIND_FAULT:    r.slot = 3'd0;
      KIND_ODOMETRY: r.slot = 3'd1;
      KIND_RANGE:    r.slot = 3'd2;
      KIND_VOLUME:   r.slot = 3'd3;
      KIND_TRACE:    r.slot = 3'd4;
      KIND_SETTING:  r.slot = 3'd5;
      default: begin
        r.valid = 1'b0;
        r.slot  = 3'd0;
      end
    endcase
    return r;
  endfunction

  // Clamp a configured length into the supported frame range.
  function automatic logic [ByteW-1:0] clamp_len(input logic [ByteW-1:0] v);
    logic [LenExtW-1:0] l;
    l = {1'b0, v};
    if (l < LenExtW'(MinFrame)) l = LenExtW'(MinFrame);
    if (l > LenExtW'(MaxFrame)) l = LenExtW'(MaxFrame);
    return l[ByteW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/typed_frame_deframer_sum8_top.sv =====
// Byte-stream frame parser with kind-selected length and 8-bit additive checksum.
`default_nettype none

// One received byte enters per word on the slave side and is registered, with
// its frame kind, position and status, for the master side; a word is taken
// every cycle that the output register is empty or the master side is ready.
// The output register is refilled in the same cycle it is drained, so
// throughput is one word per clock as long as the master side is ready. Frames
// open on the start marker, carry a kind byte that selects a configured total
// length, and close with the checksum byte and the stop marker. Any failure
// returns the parser to hunting without rescanning consumed bytes.
module typed_frame_deframer_sum8_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tfd_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [7:0] data_byte, [14:8] byte_position
  output logic [10:0]                       m_axis_tuser,   // [7:0] frame_kind, [10:8] frame_status
  output logic                              m_axis_tlast    // frame_done
);
  import tfd_pkg::*;

  logic [ByteW-1:0]  start_q, stop_q;
  logic [ByteW-1:0]  len_q [NumLen];

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  kind_q, kind_d;
  logic [ByteW-1:0]  exp_len_q, exp_len_d;
  logic [ByteW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  sum_seen_q, sum_seen_d;

  logic               out_valid_q;
  logic [ByteW-1:0]   out_data_q;
  logic [ByteW-1:0]   out_kind_q, out_kind_d;
  logic [PosW-1:0]    out_pos_q, out_pos_d;
  logic               out_done_q, out_done_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  logic               accept;
  logic [ByteW-1:0]   rx;
  kind_slot_t         slot;
  logic [LenExtW-1:0] count_ext;
  logic [LenExtW-1:0] len_ext;

  assign rx            = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot          = kind_slot(rx);
  assign count_ext     = {1'b0, count_q};
  assign len_ext       = {1'b0, exp_len_q};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      stop_q  <= '0;
      for (int i = 0; i < NumLen; i++) len_q[i] <= ByteW'(MinFrame);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START:    start_q  <= cfg_data_i;
        REG_STOP:     stop_q   <= cfg_data_i;
        REG_FAULT:    len_q[0] <= cfg_data_i;
        REG_ODOMETRY: len_q[1] <= cfg_data_i;
        REG_RANGE:    len_q[2] <= cfg_data_i;
        REG_VOLUME:   len_q[3] <= cfg_data_i;
        REG_TRACE:    len_q[4] <= cfg_data_i;
        REG_SETTING:  len_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    exp_len_d    = exp_len_q;
    count_d      = count_q;
    sum_d        = sum_q;
    sum_seen_d   = sum_seen_q;
    out_kind_d   = '0;
    out_pos_d    = '0;
    out_done_d   = 1'b0;
    out_status_d = ST_DROP;
    case (phase_q)
      PH_KIND: begin
        out_kind_d = rx;
        out_pos_d  = PosW'(1);
        if (!slot.valid) begin
          out_done_d   = 1'b1;
          out_status_d = ST_KIND;
          phase_d      = PH_HUNT;
          kind_d       = '0;
        end else begin
          kind_d       = rx;
          exp_len_d    = clamp_len(len_q[slot.slot]);
          sum_d        = sum_q + rx;
          count_d      = ByteW'(2);
          out_status_d = ST_IN;
          phase_d      = PH_BODY;
        end
      end
      PH_BODY: begin
        out_kind_d = kind_q;
        out_pos_d  = count_q[PosW-1:0];
        if (count_ext + LenExtW'(1) >= len_ext) begin
          out_done_d = 1'b1;
          if (rx != stop_q)             out_status_d = ST_STOP;
          else if (sum_seen_q != sum_q) out_status_d = ST_SUM;
          else                          out_status_d = ST_GOOD;
          phase_d = PH_HUNT;
          kind_d  = '0;
        end else begin
          if (count_ext + LenExtW'(2) == len_ext) sum_seen_d = rx;
          else                                   sum_d      = sum_q + rx;
          count_d      = count_q + ByteW'(1);
          out_status_d = ST_IN;
        end
      end
      default: begin
        // Hunt; the unused phase code behaves the same.
        phase_d = PH_HUNT;
        if (rx == start_q) begin
          sum_d        = rx;
          sum_seen_d   = '0;
          count_d      = ByteW'(1);
          kind_d       = '0;
          out_status_d = ST_IN;
          phase_d      = PH_KIND;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      kind_q      <= '0;
      exp_len_q   <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      sum_seen_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        kind_q     <= kind_d;
        exp_len_q  <= exp_len_d;
        count_q    <= count_d;
        sum_q      <= sum_d;
        sum_seen_q <= sum_seen_d;
      end
      if (accept)             out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= rx;
      out_kind_q   <= out_kind_d;
      out_pos_q    <= out_pos_d;
      out_done_q   <= out_done_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pos_q, out_data_q};
  assign m_axis_tuser  = {out_status_q, out_kind_q};
  assign m_axis_tlast  = out_done_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_done_final_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_status_q != ST_DROP && out_status_q != ST_IN)
    else $error("frame end word without final status");

  a_drop_is_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == ST_DROP |-> out_kind_q == '0 && out_pos_q == '0
      && !out_done_q)
    else $error("dropped word carries frame fields");

  a_body_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> len_ext >= LenExtW'(MinFrame) && len_ext <= LenExtW'(MaxFrame)
      && count_ext + LenExtW'(1) <= len_ext)
    else $error("frame length or count out of range");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT || phase_q == PH_KIND || phase_q == PH_BODY)
    else $error("parser phase holds unused code");
`endif

endmodule

`default_nettype wire

// ===== verif/typed_frame_deframer_sum8_top_test.sv =====
// Self-checking testbench for the typed frame deframer with 8-bit additive checksum.
module typed_frame_deframer_sum8_top_test;
  import tfd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseCount = 16;
  localparam int PhaseBytes = 100;
  localparam int DirRows    = 26;

  localparam logic [ByteW-1:0] FrameKinds [NumLen] = '{
    KIND_FAULT, KIND_ODOMETRY, KIND_RANGE, KIND_VOLUME, KIND_TRACE, KIND_SETTING
  };

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [ByteW-1:0]   kind;
    logic [PosW-1:0]    pos;
    logic               done;
    logic [StatusW-1:0] status;
  } frame_word_t;

  typedef struct packed {
    logic        known;
    frame_word_t word;
  } dir_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgW-1:0]      cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [15:0]          m_axis_tdata;   // [7:0] data_byte, [14:8] byte_position
  logic [10:0]          m_axis_tuser;   // [7:0] frame_kind, [10:8] frame_status
  logic                 m_axis_tlast;   // frame_done

  // configuration copy
  logic [ByteW-1:0]     start_cfg = '0;
  logic [ByteW-1:0]     stop_cfg  = '0;
  logic [ByteW-1:0]     len_cfg [NumLen];

  // parser state copy
  logic [PhaseW-1:0]    parse_phase = PH_HUNT;
  logic [ByteW-1:0]     held_kind   = '0;
  int                   frame_len   = 0;
  int                   frame_pos   = 0;
  logic [ByteW-1:0]     sum_acc     = '0;
  logic [ByteW-1:0]     sum_seen    = '0;

  frame_word_t          expected_words [$];
  dir_row_t             dir_rows [DirRows];
  frame_word_t          got_word;
  frame_word_t          want_word;
  int                   errors      = 0;
  int                   bytes_sent  = 0;
  int                   stall_left  = 0;
  int                   cycle_count = 0;
  bit                   steady_flow = 1'b0;

  typed_frame_deframer_sum8_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int kind_slot_of(input logic [ByteW-1:0] k);
    int slot;
    int i;
    slot = -1;
    for (i = 0; i < NumLen; i++) begin
      if (FrameKinds[i] == k) slot = i;
    end
    return slot;
  endfunction

  function automatic int frame_length(input logic [ByteW-1:0] v);
    if (v < MinFrame) return MinFrame;
    if (v > MaxFrame) return MaxFrame;
    return int'(v);
  endfunction

  // advance the parser copy by one byte and return the word it reports
  function automatic frame_word_t parse_byte(input logic [ByteW-1:0] b);
    frame_word_t w;
    int slot;
    w.data   = b;
    w.kind   = '0;
    w.pos    = '0;
    w.done   = 1'b0;
    w.status = ST_DROP;
    case (parse_phase)
      PH_KIND: begin
        slot   = kind_slot_of(b);
        w.kind = b;
        w.pos  = PosW'(1);
        if (slot < 0) begin
          w.done      = 1'b1;
          w.status    = ST_KIND;
          parse_phase = PH_HUNT;
          held_kind   = '0;
        end else begin
          held_kind   = b;
          frame_len   = frame_length(len_cfg[slot]);
          sum_acc     = sum_acc + b;
          frame_pos   = 2;
          w.status    = ST_IN;
          parse_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        w.kind = held_kind;
        w.pos  = frame_pos[PosW-1:0];
        if (frame_pos + 1 >= frame_len) begin
          w.done = 1'b1;
          if (b != stop_cfg) w.status = ST_STOP;
          else if (sum_seen != sum_acc) w.status = ST_SUM;
          else w.status = ST_GOOD;
          parse_phase = PH_HUNT;
          held_kind   = '0;
        end else begin
          if (frame_pos + 2 == frame_len) sum_seen = b;
          else sum_acc = sum_acc + b;
          frame_pos++;
          w.status = ST_IN;
        end
      end
      default: begin
        parse_phase = PH_HUNT;
        if (b == start_cfg) begin
          sum_acc     = b;
          sum_seen    = '0;
          frame_pos   = 1;
          held_kind   = '0;
          w.status    = ST_IN;
          parse_phase = PH_KIND;
        end
      end
    endcase
    return w;
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic report(input string field, input int want_v, input int got_v);
    $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
    errors++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 2) == 0) gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_words = {expected_words, parse_byte(b)};
    bytes_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      REG_START: start_cfg = v;
      REG_STOP:  stop_cfg  = v;
      default:   len_cfg[idx - REG_FAULT] = v;
    endcase
  endtask

  // one frame attempt: good, bad sum, bad stop, bad kind, cut short, or line noise
  task automatic send_frame();
    logic [ByteW-1:0] kind;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] frame_bytes [$];
    int mode;
    int len;
    int cut;
    int i;
    mode = $urandom_range(0, 99);
    if (mode >= 96) begin
      repeat ($urandom_range(1, 6)) begin
        b = ($urandom_range(0, 3) == 0) ? start_cfg : ByteW'($urandom);
        send_byte(b);
      end
      return;
    end
    kind = FrameKinds[$urandom_range(0, NumLen - 1)];
    if (mode >= 85 && mode < 90) begin
      do kind = ByteW'($urandom); while (kind_slot_of(kind) >= 0);
      send_byte(start_cfg);
      send_byte(kind);
      return;
    end
    len = frame_length(len_cfg[kind_slot_of(kind)]);
    frame_bytes = {frame_bytes, start_cfg};
    frame_bytes = {frame_bytes, kind};
    sum = start_cfg + kind;
    for (i = 2; i < len - 2; i++) begin
      b = ByteW'($urandom);
      frame_bytes = {frame_bytes, b};
      sum = sum + b;
    end
    if (mode >= 70 && mode < 78) sum = sum + ByteW'($urandom_range(1, 255));
    frame_bytes = {frame_bytes, sum};
    if (mode >= 78 && mode < 85) begin
      frame_bytes = {frame_bytes, stop_cfg ^ ByteW'($urandom_range(1, 255))};
    end else begin
      frame_bytes = {frame_bytes, stop_cfg};
    end
    cut = (mode >= 90) ? $urandom_range(1, len - 1) : len;
    for (i = 0; i < cut; i++) send_byte(frame_bytes[i]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_word.data   = m_axis_tdata[7:0];
      got_word.pos    = m_axis_tdata[14:8];
      got_word.kind   = m_axis_tuser[7:0];
      got_word.status = m_axis_tuser[10:8];
      got_word.done   = m_axis_tlast;
      if (expected_words.size() == 0) begin
        $display("%0t: word with nothing expected, data_byte %0h", $time, got_word.data);
        errors++;
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.data !== want_word.data) report("data_byte", want_word.data, got_word.data);
        if (got_word.kind !== want_word.kind) report("frame_kind", want_word.kind, got_word.kind);
        if (got_word.pos !== want_word.pos) report("byte_position", want_word.pos, got_word.pos);
        if (got_word.done !== want_word.done) report("frame_done", want_word.done, got_word.done);
        if (got_word.status !== want_word.status) begin
          report("frame_status", want_word.status, got_word.status);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left = idle_cycles() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** typed_frame_deframer_sum8_top: FAILED **");
    $finish;
  end

  initial begin
    int p;
    int r;
    int k;
    int phase_end;
    logic [CfgW-1:0] v;
    for (k = 0; k < NumLen; k++) len_cfg[k] = 8'd4;
    // reset defaults: start 0, stop 0, every length 4
    dir_rows = '{
      '{1'b1, '{8'hFF, 8'h00, 7'd0, 1'b0, ST_DROP}},
      '{1'b1, '{8'h00, 8'h00, 7'd0, 1'b0, ST_IN}},
      '{1'b1, '{8'h02, 8'h02, 7'd1, 1'b0, ST_IN}},
      '{1'b1, '{8'h02, 8'h02, 7'd2, 1'b0, ST_IN}},
      '{1'b1, '{8'h00, 8'h02, 7'd3, 1'b1, ST_GOOD}},
      '{1'b1, '{8'h00, 8'h00, 7'd0, 1'b0, ST_IN}},
      '{1'b1, '{8'h00, 8'h00, 7'd1, 1'b1, ST_KIND}},
      '{1'b1, '{8'h05, 8'h00, 7'd0, 1'b0, ST_DROP}},
      '{1'b1, '{8'h00, 8'h00, 7'd0, 1'b0, ST_IN}},
      '{1'b1, '{8'h03, 8'h03, 7'd1, 1'b0, ST_IN}},
      '{1'b1, '{8'h03, 8'h03, 7'd2, 1'b0, ST_IN}},
      '{1'b1, '{8'h01, 8'h03, 7'd3, 1'b1, ST_STOP}},
      '{1'b1, '{8'h00, 8'h00, 7'd0, 1'b0, ST_IN}},
      '{1'b1, '{8'h04, 8'h04, 7'd1, 1'b0, ST_IN}},
      '{1'b1, '{8'h05, 8'h04, 7'd2, 1'b0, ST_IN}},
      '{1'b1, '{8'h00, 8'h04, 7'd3, 1'b1, ST_SUM}},
      '{1'b1, '{8'h00, 8'h00, 7'd0, 1'b0, ST_IN}},
      '{1'b1, '{8'hFF, 8'hFF, 7'd1, 1'b1, ST_KIND}},
      '{1'b1, '{8'h00, 8'h00, 7'd0, 1'b0, ST_IN}},
      '{1'b1, '{8'h07, 8'h07, 7'd1, 1'b0, ST_IN}},
      '{1'b1, '{8'h07, 8'h07, 7'd2, 1'b0, ST_IN}},
      '{1'b1, '{8'h00, 8'h07, 7'd3, 1'b1, ST_GOOD}},
      '{1'b0, '{8'h00, 8'h00, 7'd0, 1'b0, ST_DROP}},
      '{1'b0, '{8'h08, 8'h00, 7'd0, 1'b0, ST_DROP}},
      '{1'b0, '{8'h08, 8'h00, 7'd0, 1'b0, ST_DROP}},
      '{1'b0, '{8'h00, 8'h00, 7'd0, 1'b0, ST_DROP}}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DirRows; k++) begin
      send_byte(dir_rows[k].word.data);
      if (dir_rows[k].known) expected_words[expected_words.size() - 1] = dir_rows[k].word;
    end
    drain();

    for (p = 0; p < PhaseCount; p++) begin
      for (r = 0; r < 8; r++) begin
        if (r == REG_START) v = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : CfgW'($urandom);
        else if (r == REG_STOP) v = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : CfgW'($urandom);
        else if (p == 0) v = 8'h00;
        else if (p == 1) v = r[0] ? 8'hFF : 8'd128;
        else if (p == 2) v = r[0] ? 8'd3 : 8'd129;
        else begin
          k = $urandom_range(0, 99);
          if (k < 80) v = CfgW'($urandom_range(4, 10));
          else if (k < 90) v = CfgW'($urandom_range(0, 3));
          else if (k < 95) v = CfgW'($urandom_range(11, 40));
          else v = CfgW'($urandom_range(120, 255));
        end
        write_reg(CfgIdxW'(r), v);
      end
      cfg_we_i <= 1'b0;
      steady_flow = (p % 5 == 3);
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_frame();
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("** typed_frame_deframer_sum8_top: PASSED **");
    end else begin
      $display("** typed_frame_deframer_sum8_top: FAILED **");
    end
    $finish;
  end

endmodule
